// ===== hw/rtl/qte_pkg.sv =====
// Shared types and constants of the quaternion to Euler angle pipeline.
// Used by the front end, the square-root and CORDIC steps and the top level.
package qte_pkg;

  // Width of CORDIC vector components and of the side payload sums
  localparam int VW = 36;
  // Width of the angle accumulator, units of 2^-30 rad
  localparam int ZW = 35;
  // Width of the saturated arcsine argument, Q2.28
  localparam int SW = 30;
  // Width of the square-root radicand and root
  localparam int NW = 58;
  // Square-root steps: bit positions 56 down to 0 by two
  localparam int SQ_STEPS = 29;
  localparam int NUM_LANES = 3;

  localparam logic signed [VW-1:0] ONE_Q28 = VW'(64'sd268435456);
  localparam logic [NW-1:0]        ONE_Q56 = NW'(1) << 56;
  localparam logic signed [ZW-1:0] ANG_PI = ZW'(64'sd3373259426);
  localparam logic signed [ZW-1:0] ROUND_HALF = ZW'(64'sd65536);
  localparam int RSHIFT = 17;
  localparam logic signed [ZW-RSHIFT-1:0] ANG_MAX = (ZW-RSHIFT)'(25736);
  localparam logic signed [ZW-RSHIFT-1:0] PITCH_MAX = (ZW-RSHIFT)'(12868);

  // Lane indexes
  localparam int LANE_HEADING = 0;
  localparam int LANE_PITCH = 1;
  localparam int LANE_BANK = 2;

  // Rounded atan(2^-i) * 2^30
  localparam logic signed [ZW-1:0] ATAN_TAB [24] = '{
    ZW'(64'sd843314857), ZW'(64'sd497837829), ZW'(64'sd263043837),
    ZW'(64'sd133525159), ZW'(64'sd67021687),  ZW'(64'sd33543516),
    ZW'(64'sd16775851),  ZW'(64'sd8388437),   ZW'(64'sd4194283),
    ZW'(64'sd2097149),   ZW'(64'sd1048576),   ZW'(64'sd524288),
    ZW'(64'sd262144),    ZW'(64'sd131072),    ZW'(64'sd65536),
    ZW'(64'sd32768),     ZW'(64'sd16384),     ZW'(64'sd8192),
    ZW'(64'sd4096),      ZW'(64'sd2048),      ZW'(64'sd1024),
    ZW'(64'sd512),       ZW'(64'sd256),       ZW'(64'sd128)
  };

  // One CORDIC lane: vector, angle and the both-arguments-zero flag
  typedef struct packed {
    logic signed [VW-1:0] x;
    logic signed [VW-1:0] y;
    logic signed [ZW-1:0] z;
    logic                 zero;
  } vec_t;

  // Operands that travel alongside the square root
  typedef struct packed {
    logic signed [VW-1:0] hn;
    logic signed [VW-1:0] hd;
    logic signed [VW-1:0] bn;
    logic signed [VW-1:0] bd;
    logic signed [SW-1:0] s;
  } side_t;

endpackage

// ===== hw/rtl/qte_front.sv =====
// Front end: component products, atan2 operands, saturated arcsine
// argument and the square-root radicand. Four register stages; uses qte_pkg.
module qte_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  logic signed [15:0]  quat_w_i,
  input  logic signed [15:0]  quat_x_i,
  input  logic signed [15:0]  quat_y_i,
  input  logic signed [15:0]  quat_z_i,
  output logic                valid_o,
  output logic [qte_pkg::NW-1:0] n_o,
  output qte_pkg::side_t      side_o
);
  import qte_pkg::*;

  logic [3:0] valid_q;

  logic signed [31:0] p_ww_q, p_xx_q, p_yy_q, p_zz_q;
  logic signed [31:0] p_xy_q, p_zw_q, p_yz_q, p_xw_q, p_xz_q, p_yw_q;

  side_t side_d, side2_q, side3_q, side4_q;
  logic signed [VW-1:0] s_full;
  logic signed [SW-1:0] s_abs;
  logic [28:0] s_mag;
  logic [NW-1:0] ssq_d, ssq_q, n_q;

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[2:0], valid_i};
    end
  end

  // Stage 1: products
  always_ff @(posedge clk_i) begin
    p_ww_q <= quat_w_i * quat_w_i;
    p_xx_q <= quat_x_i * quat_x_i;
    p_yy_q <= quat_y_i * quat_y_i;
    p_zz_q <= quat_z_i * quat_z_i;
    p_xy_q <= quat_x_i * quat_y_i;
    p_zw_q <= quat_z_i * quat_w_i;
    p_yz_q <= quat_y_i * quat_z_i;
    p_xw_q <= quat_x_i * quat_w_i;
    p_xz_q <= quat_x_i * quat_z_i;
    p_yw_q <= quat_y_i * quat_w_i;
  end

  // Stage 2: sums, saturate the arcsine argument
  always_comb begin
    side_d.hn = (VW'(p_xy_q) + VW'(p_zw_q)) <<< 1;
    side_d.hd = VW'(p_xx_q) - VW'(p_yy_q) - VW'(p_zz_q) + VW'(p_ww_q);
    side_d.bn = (VW'(p_yz_q) + VW'(p_xw_q)) <<< 1;
    side_d.bd = VW'(p_zz_q) + VW'(p_ww_q) - VW'(p_xx_q) - VW'(p_yy_q);
    s_full = (VW'(p_yw_q) - VW'(p_xz_q)) <<< 1;
    priority if (s_full > ONE_Q28) begin
      side_d.s = SW'(ONE_Q28);
    end else if (s_full < -ONE_Q28) begin
      side_d.s = SW'(-ONE_Q28);
    end else begin
      side_d.s = SW'(s_full);
    end
  end

  // Stage 3: square the argument magnitude
  always_comb begin
    s_abs = (side2_q.s < 0) ? -side2_q.s : side2_q.s;
    s_mag = s_abs[28:0];
    ssq_d = s_mag * s_mag;
  end

  // Hold operands through stages 2 to 4
  always_ff @(posedge clk_i) begin
    side2_q <= side_d;
    side3_q <= side2_q;
    ssq_q   <= ssq_d;
    side4_q <= side3_q;
    n_q     <= ONE_Q56 - ssq_q;
  end

  assign valid_o = valid_q[3];
  assign n_o     = n_q;
  assign side_o  = side4_q;

endmodule

// ===== hw/rtl/qte_sqrt_step.sv =====
// One registered step of the floor integer square root (one result bit).
// Uses qte_pkg for widths.
module qte_sqrt_step #(
  parameter int BIT_POS = 56
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   valid_i,
  input  logic [qte_pkg::NW-1:0] n_i,
  input  logic [qte_pkg::NW-1:0] res_i,
  output logic                   valid_o,
  output logic [qte_pkg::NW-1:0] n_o,
  output logic [qte_pkg::NW-1:0] res_o
);
  import qte_pkg::*;

  localparam logic [NW-1:0] BitVal = NW'(1) << BIT_POS;

  logic          valid_q;
  logic [NW-1:0] trial, n_d, res_d, n_q, res_q;

  // Subtract the trial value where it fits
  always_comb begin
    trial = res_i + BitVal;
    if (n_i >= trial) begin
      n_d   = n_i - trial;
      res_d = (res_i >> 1) + BitVal;
    end else begin
      n_d   = n_i;
      res_d = res_i >> 1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q   <= n_d;
    res_q <= res_d;
  end

  assign valid_o = valid_q;
  assign n_o     = n_q;
  assign res_o   = res_q;

endmodule

// ===== hw/rtl/qte_cordic_step.sv =====
// One registered vectoring CORDIC iteration for all three angle lanes.
// Uses qte_pkg for the lane type and the arctangent table.
module qte_cordic_step #(
  parameter int SHIFT = 0
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    valid_i,
  input  qte_pkg::vec_t [qte_pkg::NUM_LANES-1:0]  vec_i,
  output logic                                    valid_o,
  output qte_pkg::vec_t [qte_pkg::NUM_LANES-1:0]  vec_o
);
  import qte_pkg::*;

  logic valid_q;
  vec_t [NUM_LANES-1:0] vec_d, vec_q;

  // Rotate each lane toward the x axis
  always_comb begin
    for (int l = 0; l < NUM_LANES; l++) begin
      vec_d[l].zero = vec_i[l].zero;
      if (vec_i[l].y > 0) begin
        vec_d[l].x = vec_i[l].x + (vec_i[l].y >>> SHIFT);
        vec_d[l].y = vec_i[l].y - (vec_i[l].x >>> SHIFT);
        vec_d[l].z = vec_i[l].z + ATAN_TAB[SHIFT];
      end else begin
        vec_d[l].x = vec_i[l].x - (vec_i[l].y >>> SHIFT);
        vec_d[l].y = vec_i[l].y + (vec_i[l].x >>> SHIFT);
        vec_d[l].z = vec_i[l].z - ATAN_TAB[SHIFT];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    vec_q <= vec_d;
  end

  assign valid_o = valid_q;
  assign vec_o   = vec_q;

endmodule

// ===== hw/rtl/quaternion_to_euler_angles.sv =====
// Top level of the quaternion to Euler angle converter: front end, square
// root chain, CORDIC chain and output rounding. Uses qte_pkg and all submodules.
//
//   channel  | handshake          | payload
//   ---------+--------------------+-----------------------------------------
//   input    | start_i, busy_o    | quat_w_i, quat_x_i, quat_y_i, quat_z_i
//   result   | done_o (strobe)    | heading_angle_o, pitch_angle_o, bank_angle_o
//
// A transfer is taken at every edge with start_i high; busy_o stays low.
// The path runs through the front end, the 29-step square root, the
// pre-rotation register, one CORDIC iteration per stage and the output register.
// Reset clears only the valid bits; results leave as one-cycle done_o strobes.
// The receiver cannot stall, so the pipeline never holds.
module quaternion_to_euler_angles #(
  parameter int CORDIC_ITERATIONS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic signed [15:0] quat_w_i,
  input  logic signed [15:0] quat_x_i,
  input  logic signed [15:0] quat_y_i,
  input  logic signed [15:0] quat_z_i,
  output logic               done_o,
  output logic signed [15:0] heading_angle_o,
  output logic signed [14:0] pitch_angle_o,
  output logic signed [15:0] bank_angle_o
);
  import qte_pkg::*;

  localparam int NumIter = (CORDIC_ITERATIONS > 24) ? 24 : CORDIC_ITERATIONS;
  localparam int RW = ZW - RSHIFT;

  // Front end
  logic          fr_valid;
  logic [NW-1:0] fr_n;
  side_t         fr_side;

  qte_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (start_i),
    .quat_w_i (quat_w_i),
    .quat_x_i (quat_x_i),
    .quat_y_i (quat_y_i),
    .quat_z_i (quat_z_i),
    .valid_o  (fr_valid),
    .n_o      (fr_n),
    .side_o   (fr_side)
  );

  // Square-root chain with the side operands carried along
  logic          sq_valid [SQ_STEPS+1];
  logic [NW-1:0] sq_n     [SQ_STEPS+1];
  logic [NW-1:0] sq_res   [SQ_STEPS+1];
  side_t         sq_side  [SQ_STEPS+1];

  assign sq_valid[0] = fr_valid;
  assign sq_n[0]     = fr_n;
  assign sq_res[0]   = '0;
  assign sq_side[0]  = fr_side;

  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
    qte_sqrt_step #(
      .BIT_POS (2 * (SQ_STEPS - 1 - k))
    ) u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (sq_valid[k]),
      .n_i     (sq_n[k]),
      .res_i   (sq_res[k]),
      .valid_o (sq_valid[k+1]),
      .n_o     (sq_n[k+1]),
      .res_o   (sq_res[k+1])
    );

    always_ff @(posedge clk_i) begin
      sq_side[k+1] <= sq_side[k];
    end
  end

  // Pre-rotation: fold the left half-plane, flag the all-zero vector
  logic signed [VW-1:0] lane_y [NUM_LANES];
  logic signed [VW-1:0] lane_x [NUM_LANES];
  vec_t [NUM_LANES-1:0] pre_d, pre_q;
  logic                 pre_valid_q;

  always_comb begin
    lane_y[LANE_HEADING] = sq_side[SQ_STEPS].hn;
    lane_x[LANE_HEADING] = sq_side[SQ_STEPS].hd;
    lane_y[LANE_PITCH]   = VW'(sq_side[SQ_STEPS].s);
    lane_x[LANE_PITCH]   = signed'(VW'(sq_res[SQ_STEPS]));
    lane_y[LANE_BANK]    = sq_side[SQ_STEPS].bn;
    lane_x[LANE_BANK]    = sq_side[SQ_STEPS].bd;
    for (int l = 0; l < NUM_LANES; l++) begin
      pre_d[l].zero = (lane_x[l] == '0) && (lane_y[l] == '0);
      if (lane_x[l] < 0) begin
        pre_d[l].x = -lane_x[l];
        pre_d[l].y = -lane_y[l];
        pre_d[l].z = (lane_y[l] >= 0) ? ANG_PI : -ANG_PI;
      end else begin
        pre_d[l].x = lane_x[l];
        pre_d[l].y = lane_y[l];
        pre_d[l].z = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pre_valid_q <= 1'b0;
    end else begin
      pre_valid_q <= sq_valid[SQ_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    pre_q <= pre_d;
  end

  // CORDIC chain, one iteration per stage
  logic                 cr_valid [NumIter+1];
  vec_t [NUM_LANES-1:0] cr_vec   [NumIter+1];

  assign cr_valid[0] = pre_valid_q;
  assign cr_vec[0]   = pre_q;

  for (genvar i = 0; i < NumIter; i++) begin : g_cordic
    qte_cordic_step #(
      .SHIFT (i)
    ) u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (cr_valid[i]),
      .vec_i   (cr_vec[i]),
      .valid_o (cr_valid[i+1]),
      .vec_o   (cr_vec[i+1])
    );
  end

  // Round half up to Q3.13 and clamp
  logic signed [ZW-1:0] z_rnd [NUM_LANES];
  logic signed [RW-1:0] ang   [NUM_LANES];
  logic signed [RW-1:0] lim   [NUM_LANES];
  logic signed [RW-1:0] ang_c [NUM_LANES];

  always_comb begin
    lim[LANE_HEADING] = ANG_MAX;
    lim[LANE_PITCH]   = PITCH_MAX;
    lim[LANE_BANK]    = ANG_MAX;
    for (int l = 0; l < NUM_LANES; l++) begin
      z_rnd[l] = cr_vec[NumIter][l].z + ROUND_HALF;
      ang[l]   = RW'(z_rnd[l] >>> RSHIFT);
      priority if (cr_vec[NumIter][l].zero) begin
        ang_c[l] = '0;
      end else if (ang[l] > lim[l]) begin
        ang_c[l] = lim[l];
      end else if (ang[l] < -lim[l]) begin
        ang_c[l] = -lim[l];
      end else begin
        ang_c[l] = ang[l];
      end
    end
  end

  // Register results and the strobe
  logic               done_q;
  logic signed [15:0] heading_q, bank_q;
  logic signed [14:0] pitch_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= cr_valid[NumIter];
    end
  end

  always_ff @(posedge clk_i) begin
    heading_q <= ang_c[LANE_HEADING][15:0];
    pitch_q   <= ang_c[LANE_PITCH][14:0];
    bank_q    <= ang_c[LANE_BANK][15:0];
  end

  assign busy_o          = 1'b0;
  assign done_o          = done_q;
  assign heading_angle_o = heading_q;
  assign pitch_angle_o   = pitch_q;
  assign bank_angle_o    = bank_q;

endmodule
